/* rtl/kplr_pkg.sv */
// Shared types, widths, codes and defaults of the key press classifier.
package kplr_pkg;

    localparam int NUM_KEYS_DEF         = 12;
    localparam int SWITCH_FIRST_KEY_DEF = 7;
    localparam int SWITCH_POSITIONS_DEF = 5;

    localparam int MASK_BITS  = 12;
    localparam int KEY_W      = 4;
    localparam int EVT_W      = 3;
    localparam int SEQ_W      = 32;
    localparam int SW_W       = 3;
    localparam int PERIOD_W   = 16;
    localparam int COUNT_W    = 8;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam logic [EVT_W-1:0] EV_PRESS   = 3'd0;
    localparam logic [EVT_W-1:0] EV_RELEASE = 3'd1;
    localparam logic [EVT_W-1:0] EV_SHORT   = 3'd2;
    localparam logic [EVT_W-1:0] EV_LONG    = 3'd3;
    localparam logic [EVT_W-1:0] EV_REPEAT  = 3'd4;

    localparam logic OP_KEYS = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PRESS_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TIMEOUT = 2'd2;

    localparam logic [PERIOD_W-1:0]  PRESS_PERIOD_RST    = 16'd150;
    localparam logic [COUNT_W-1:0]   LONG_COUNT_RST      = 8'd2;
    localparam logic [TIMEOUT_W-1:0] STARTUP_TIMEOUT_RST = 16'd1500;

    // events one key produces for one input item
    typedef struct packed {
        logic press_ev;
        logic short_ev;
        logic rel_ev;
        logic long_ev;
        logic rpt_ev;
    } kplr_flags_t;

    // merge stage status seen by the top level
    typedef struct packed {
        logic            busy;
        logic            startup_done;
        logic [SW_W-1:0] sw_state;
    } kplr_status_t;

endpackage

/* rtl/key_press_long_repeat_classifier.sv */
// Top level of the key press classifier: config registers, key lanes, merge stage.
//
// Usage notes:
//  - s_axis: one transaction per input item. tuser[0] selects the kind:
//    0 = key masks in tdata, 1 = one-millisecond tick (tdata ignored).
//  - m_axis: one transaction per result; tlast marks the final result of an item.
//  - cfg: register writes (press_period, long_count, startup_timeout),
//    always ready; write only while the block is idle.
//  - Each key has a lane that updates its hold timer and count in the cycle
//    the item is accepted; the merge stage then sends the events out one per
//    cycle in key order while m_axis_tready is high.
//  - The item's events are registered in the merge stage's pending flags,
//    and each result then in the output register. s_axis_tready stays low
//    until every result of the item has moved to the output register, so
//    no new item is taken before then. Up to 36 results per item.
//  - Stall: the output register holds its result while m_axis_tready is low
//    and the merge stage waits; no events are lost.
//  - Reset: timers stopped, counts and sequence numbers zero, switch position
//    unknown, config registers at their defaults. No clearing pass.
module key_press_long_repeat_classifier #(
    parameter int NUM_KEYS         = kplr_pkg::NUM_KEYS_DEF,
    parameter int SWITCH_FIRST_KEY = kplr_pkg::SWITCH_FIRST_KEY_DEF,
    parameter int SWITCH_POSITIONS = kplr_pkg::SWITCH_POSITIONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [11:0] press_mask, [23:12] release_mask
    input  logic [kplr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] key, [35:4] sequence_res, [38:36] switch state, [39] zero
    output logic [kplr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [2:0] event_type
    output logic [kplr_pkg::EVT_W-1:0]      m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kplr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kplr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kplr_pkg::*;

    // keys at or above the mask width never see an event
    localparam int LANES = (NUM_KEYS < MASK_BITS) ? NUM_KEYS : MASK_BITS;

    logic [PERIOD_W-1:0]  press_period_reg;
    logic [COUNT_W-1:0]   long_count_reg;
    logic [TIMEOUT_W-1:0] startup_timeout_reg;
    logic [PERIOD_W-1:0]  period_eff;

    logic              accept;
    logic              op;
    logic [MASK_BITS-1:0] press_mask;
    logic [MASK_BITS-1:0] release_mask;

    kplr_flags_t       flags   [LANES];
    logic [SEQ_W-1:0]  key_seq [LANES];
    logic [LANES-1:0]  seq_we;
    logic [SEQ_W-1:0]  seq_wdata;
    kplr_status_t      status;

    logic [KEY_W-1:0]  m_key;
    logic [SEQ_W-1:0]  m_seq;
    logic [SW_W-1:0]   m_sw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_period_reg    <= PRESS_PERIOD_RST;
            long_count_reg      <= LONG_COUNT_RST;
            startup_timeout_reg <= STARTUP_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PRESS_PERIOD:    press_period_reg    <= cfg_data;
                REG_LONG_COUNT:      long_count_reg      <= cfg_data[COUNT_W-1:0];
                REG_STARTUP_TIMEOUT: startup_timeout_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // a zero period expires on every tick
    assign period_eff = (press_period_reg == '0) ? PERIOD_W'(1) : press_period_reg;

    // new items wait until every event of the previous one has left the merge stage's pending flags
    assign s_axis_tready = !status.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = s_axis_tuser[0];
    assign press_mask    = s_axis_tdata[MASK_BITS-1:0];
    assign release_mask  = s_axis_tdata[2*MASK_BITS-1:MASK_BITS];

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        kplr_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .accept     (accept),
            .op         (op),
            .press_bit  (press_mask[g]),
            .rel_bit    (release_mask[g]),
            .period     (period_eff),
            .long_count (long_count_reg),
            .seq_we     (seq_we[g]),
            .seq_wdata  (seq_wdata),
            .flags      (flags[g]),
            .key_seq    (key_seq[g])
        );
    end

    kplr_merge #(
        .LANES            (LANES),
        .SWITCH_FIRST_KEY (SWITCH_FIRST_KEY),
        .SWITCH_POSITIONS (SWITCH_POSITIONS)
    ) u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .op              (op),
        .startup_timeout (startup_timeout_reg),
        .flags           (flags),
        .key_seq         (key_seq),
        .seq_we          (seq_we),
        .seq_wdata       (seq_wdata),
        .status          (status),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .m_key           (m_key),
        .m_type          (m_axis_tuser),
        .m_seq           (m_seq),
        .m_sw            (m_sw),
        .m_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, m_sw, m_seq, m_key};

    // once the startup timeout has fired the position is never unknown again
    a_known_after_startup: assert property (@(posedge clk) disable iff (!rst_n)
        status.startup_done |-> status.sw_state != SW_W'(SWITCH_POSITIONS))
        else $error("switch position unknown after startup timeout");

    // a result only names a key that has a lane
    a_key_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[KEY_W-1:0] < KEY_W'(LANES))
        else $error("result key index out of range");

    // an accepted press of a served key always leaves events to deliver
    a_press_gives_events: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_KEYS && (|press_mask[LANES-1:0])) |=> status.busy)
        else $error("press transaction produced no pending events");

endmodule

/* rtl/kplr_lane.sv */
// Per-key lane: hold timer, hold count, stored sequence number, event flags.
module kplr_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          op,
    input  logic                          press_bit,
    input  logic                          rel_bit,
    input  logic [kplr_pkg::PERIOD_W-1:0] period,
    input  logic [kplr_pkg::COUNT_W-1:0]  long_count,
    input  logic                          seq_we,
    input  logic [kplr_pkg::SEQ_W-1:0]    seq_wdata,
    output kplr_pkg::kplr_flags_t         flags,
    output logic [kplr_pkg::SEQ_W-1:0]    key_seq
);
    import kplr_pkg::*;

    logic                running_reg, running_next;
    logic [PERIOD_W-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_W-1:0]  hold_reg, hold_next;
    logic [SEQ_W-1:0]    seq_reg;
    logic [PERIOD_W:0]   elapsed_inc;
    logic [COUNT_W:0]    hold_inc;

    assign elapsed_inc = {1'b0, elapsed_reg} + {{PERIOD_W{1'b0}}, 1'b1};
    assign hold_inc    = {1'b0, hold_reg} + {{COUNT_W{1'b0}}, 1'b1};
    assign key_seq     = seq_reg;

    always_comb
    begin
        flags        = '0;
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        hold_next    = hold_reg;
        if (accept)
        begin
            if (op == OP_KEYS)
            begin
                if (press_bit)
                begin
                    flags.press_ev = 1'b1;
                    running_next   = 1'b1;
                    elapsed_next   = '0;
                end
                if (rel_bit)
                begin
                    flags.rel_ev   = 1'b1;
                    flags.short_ev = (hold_reg < long_count);
                    running_next   = 1'b0;
                    elapsed_next   = '0;
                    hold_next      = '0;
                end
            end
            else if (running_reg)
            begin
                if (elapsed_inc >= {1'b0, period})
                begin
                    elapsed_next = '0;
                    if (hold_inc == {1'b0, long_count})
                    begin
                        flags.long_ev = 1'b1;
                        hold_next     = hold_inc[COUNT_W-1:0];
                    end
                    else if (hold_inc > {1'b0, long_count})
                    begin
                        flags.rpt_ev = 1'b1;
                    end
                    else
                    begin
                        hold_next = hold_inc[COUNT_W-1:0];
                    end
                end
                else
                begin
                    elapsed_next = elapsed_inc[PERIOD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            elapsed_reg <= '0;
            hold_reg    <= '0;
            seq_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
            hold_reg    <= hold_next;
            if (seq_we)
            begin
                seq_reg <= seq_wdata;
            end
        end
    end

endmodule

/* rtl/kplr_merge.sv */
// Merge stage: walks lane events in key order, numbers presses, tracks switch position and startup timeout.
module kplr_merge #(
    parameter int LANES            = kplr_pkg::NUM_KEYS_DEF,
    parameter int SWITCH_FIRST_KEY = kplr_pkg::SWITCH_FIRST_KEY_DEF,
    parameter int SWITCH_POSITIONS = kplr_pkg::SWITCH_POSITIONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           op,
    input  logic [kplr_pkg::TIMEOUT_W-1:0] startup_timeout,
    input  kplr_pkg::kplr_flags_t          flags   [LANES],
    input  logic [kplr_pkg::SEQ_W-1:0]     key_seq [LANES],
    output logic [LANES-1:0]               seq_we,
    output logic [kplr_pkg::SEQ_W-1:0]     seq_wdata,
    output kplr_pkg::kplr_status_t         status,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [kplr_pkg::KEY_W-1:0]     m_key,
    output logic [kplr_pkg::EVT_W-1:0]     m_type,
    output logic [kplr_pkg::SEQ_W-1:0]     m_seq,
    output logic [kplr_pkg::SW_W-1:0]      m_sw,
    output logic                           m_last
);
    import kplr_pkg::*;

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [SW_W-1:0] SW_UNKNOWN = SW_W'(SWITCH_POSITIONS);
    localparam logic [5:0] SW_LO = 6'(SWITCH_FIRST_KEY);
    localparam logic [5:0] SW_HI = 6'(SWITCH_FIRST_KEY + SWITCH_POSITIONS);

    logic [LANES-1:0] press_reg, short_reg, rel_reg, long_reg, rpt_reg;
    logic [LANES-1:0] press_next, short_next, rel_next, long_next, rpt_next;
    logic [LANES-1:0] pend_any;

    logic [SEQ_W-1:0]     gseq_reg, gseq_next;
    logic [SW_W-1:0]      sw_reg, sw_next;
    logic [TIMEOUT_W-1:0] se_reg, se_next, se_inc;
    logic                 done_reg, done_next;

    logic                 out_valid_reg;
    logic [KEY_W-1:0]     out_key_reg;
    logic [EVT_W-1:0]     out_type_reg;
    logic [SEQ_W-1:0]     out_seq_reg;
    logic [SW_W-1:0]      out_sw_reg;
    logic                 out_last_reg;

    logic [LANE_W-1:0] sel;
    logic              found;
    logic              emit;
    logic [EVT_W-1:0]  sel_type;
    logic [SEQ_W-1:0]  sel_seq;
    logic [SW_W-1:0]   sel_sw;
    logic [5:0]        sel_key6;
    logic              sel_last;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            pend_any[i] = press_reg[i] | short_reg[i] | rel_reg[i] | long_reg[i] | rpt_reg[i];
        end
    end

    // lowest key with events left
    always_comb
    begin
        sel = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (pend_any[i])
            begin
                sel = LANE_W'(i);
            end
        end
    end

    assign found    = |pend_any;
    assign emit     = found && (!out_valid_reg || m_ready);
    assign sel_key6 = 6'(sel);

    always_comb
    begin
        press_next = press_reg;
        short_next = short_reg;
        rel_next   = rel_reg;
        long_next  = long_reg;
        rpt_next   = rpt_reg;
        sel_type   = EV_REPEAT;
        // within one key: press, short, release, then expiry events
        if (press_reg[sel])
        begin
            sel_type        = EV_PRESS;
            press_next[sel] = 1'b0;
        end
        else if (short_reg[sel])
        begin
            sel_type        = EV_SHORT;
            short_next[sel] = 1'b0;
        end
        else if (rel_reg[sel])
        begin
            sel_type      = EV_RELEASE;
            rel_next[sel] = 1'b0;
        end
        else if (long_reg[sel])
        begin
            sel_type       = EV_LONG;
            long_next[sel] = 1'b0;
        end
        else
        begin
            rpt_next[sel] = 1'b0;
        end
        sel_last = ~|(press_next | short_next | rel_next | long_next | rpt_next);
    end

    always_comb
    begin
        gseq_next = gseq_reg + {{(SEQ_W-1){1'b0}}, 1'b1};
        sel_seq   = (sel_type == EV_PRESS) ? gseq_next : key_seq[sel];
        sel_sw    = sw_reg;
        if (sel_type == EV_PRESS && sel_key6 >= SW_LO && sel_key6 < SW_HI)
        begin
            sel_sw = SW_W'(sel_key6 - SW_LO);
        end
    end

    always_comb
    begin
        seq_we = '0;
        if (emit && sel_type == EV_PRESS)
        begin
            seq_we[sel] = 1'b1;
        end
    end
    assign seq_wdata = gseq_next;

    // startup timeout, evaluated on each accepted tick until it has fired
    always_comb
    begin
        se_inc    = (se_reg != {TIMEOUT_W{1'b1}}) ? se_reg + TIMEOUT_W'(1) : se_reg;
        se_next   = se_reg;
        done_next = done_reg;
        sw_next   = sw_reg;
        if (accept && op == OP_TICK && !done_reg)
        begin
            se_next = se_inc;
            if (se_inc >= startup_timeout)
            begin
                done_next = 1'b1;
                if (sw_reg == SW_UNKNOWN)
                begin
                    sw_next = '0;
                end
            end
        end
        else if (emit)
        begin
            sw_next = sel_sw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_reg     <= '0;
            short_reg     <= '0;
            rel_reg       <= '0;
            long_reg      <= '0;
            rpt_reg       <= '0;
            gseq_reg      <= '0;
            sw_reg        <= SW_UNKNOWN;
            se_reg        <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sw_reg   <= sw_next;
            se_reg   <= se_next;
            done_reg <= done_next;
            if (accept)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    press_reg[i] <= flags[i].press_ev;
                    short_reg[i] <= flags[i].short_ev;
                    rel_reg[i]   <= flags[i].rel_ev;
                    long_reg[i]  <= flags[i].long_ev;
                    rpt_reg[i]   <= flags[i].rpt_ev;
                end
            end
            else if (emit)
            begin
                press_reg <= press_next;
                short_reg <= short_next;
                rel_reg   <= rel_next;
                long_reg  <= long_next;
                rpt_reg   <= rpt_next;
                if (sel_type == EV_PRESS)
                begin
                    gseq_reg <= gseq_next;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_key_reg  <= KEY_W'(sel);
            out_type_reg <= sel_type;
            out_seq_reg  <= sel_seq;
            out_sw_reg   <= sel_sw;
            out_last_reg <= sel_last;
        end
    end

    assign status.busy         = found;
    assign status.startup_done = done_reg;
    assign status.sw_state     = sw_reg;

    assign m_valid = out_valid_reg;
    assign m_key   = out_key_reg;
    assign m_type  = out_type_reg;
    assign m_seq   = out_seq_reg;
    assign m_sw    = out_sw_reg;
    assign m_last  = out_last_reg;

endmodule

/* verif/key_press_long_repeat_classifier_tb.sv */
// Self-checking testbench for the key press long/repeat classifier.
`timescale 1ns / 1ps

module key_press_long_repeat_classifier_tb;
    import kplr_pkg::*;

    localparam int N_KEYS    = NUM_KEYS_DEF;
    localparam int SW_FIRST  = SWITCH_FIRST_KEY_DEF;
    localparam int SW_COUNT  = SWITCH_POSITIONS_DEF;
    localparam logic [SW_W-1:0] SW_UNKNOWN = SW_W'(SWITCH_POSITIONS_DEF);
    localparam logic [SW_W-1:0] SW_BUSY    = '0;
    // index 3 decodes to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int SETTLE     = 6;      // cycles after the last result before going idle
    localparam int LIMIT      = 600000; // cycle budget for the whole run
    localparam int N_PHASES   = 6;
    localparam int PHASE_ITEMS = 60;

    // random phase settings: period zero and long count zero / 255 are the odd corners
    localparam logic [15:0] PHASE_PERIOD [N_PHASES] =
        '{16'd1, 16'd3, 16'd0, 16'd2, 16'd1, 16'd65535};
    localparam logic [7:0] PHASE_LONG [N_PHASES] =
        '{8'd1, 8'd3, 8'd0, 8'd254, 8'd255, 8'd2};
    localparam logic [15:0] PHASE_TIMEOUT [N_PHASES] =
        '{16'd0, 16'd65535, 16'd1, 16'd0, 16'd500, 16'd65535};

    // one result as it leaves the block
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [EVT_W-1:0] evt;
        logic [SEQ_W-1:0] seq;
        logic [SW_W-1:0]  sw;
        logic             last;
    } key_event_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // directed row: either an input item or a register write,
    // with the count and first result typed in where obvious
    typedef struct packed {
        row_kind_t            kind;
        logic                 op;
        logic [11:0]          pm;
        logic [11:0]          rm;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [15:0]          reg_val;
        logic                 has_exp;
        logic [5:0]           exp_cnt;
        logic [KEY_W-1:0]     exp_key;
        logic [EVT_W-1:0]     exp_evt;
        logic [SEQ_W-1:0]     exp_seq;
        logic [SW_W-1:0]      exp_sw;
    } plan_row_t;

    localparam int PLAN_LEN = 28;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // fresh out of reset: press/release of key 0, release of a never-pressed key
        '{ROW_ITEM, OP_KEYS, 12'h001, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd1, 4'd0, EV_PRESS, 32'd1, SW_UNKNOWN},
        '{ROW_ITEM, OP_KEYS, 12'h000, 12'h001, REG_UNUSED, 16'd0,
          1'b1, 6'd2, 4'd0, EV_SHORT, 32'd1, SW_UNKNOWN},
        '{ROW_ITEM, OP_KEYS, 12'h000, 12'h008, REG_UNUSED, 16'd0,
          1'b1, 6'd2, 4'd3, EV_SHORT, 32'd0, SW_UNKNOWN},
        // tick with junk in tdata, then an empty mask item
        '{ROW_ITEM, OP_TICK, 12'hFFF, 12'hFFF, REG_UNUSED, 16'd0,
          1'b1, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_UNKNOWN},
        '{ROW_ITEM, OP_KEYS, 12'h000, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_UNKNOWN},
        // short startup timeout, reached on the third tick with a key held
        '{ROW_CFG, OP_KEYS, 12'h000, 12'h000, REG_STARTUP_TIMEOUT, 16'd3,
          1'b0, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_UNKNOWN},
        '{ROW_ITEM, OP_TICK, 12'h000, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_UNKNOWN},
        '{ROW_ITEM, OP_KEYS, 12'h002, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd1, 4'd1, EV_PRESS, 32'd2, SW_UNKNOWN},
        '{ROW_ITEM, OP_TICK, 12'h000, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_UNKNOWN},
        '{ROW_CFG, OP_KEYS, 12'h000, 12'h000, REG_PRESS_PERIOD, 16'd1,
          1'b0, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_UNKNOWN},
        '{ROW_CFG, OP_KEYS, 12'h000, 12'h000, REG_STARTUP_TIMEOUT, 16'd65535,
          1'b0, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_UNKNOWN},
        '{ROW_CFG, OP_KEYS, 12'h000, 12'h000, REG_UNUSED, 16'hFFFF,
          1'b0, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_UNKNOWN},
        // key 1 held: count 1, then long, then repeat; position now busy
        '{ROW_ITEM, OP_TICK, 12'h000, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_BUSY},
        '{ROW_ITEM, OP_TICK, 12'h000, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd1, 4'd1, EV_LONG, 32'd2, SW_BUSY},
        '{ROW_ITEM, OP_TICK, 12'h000, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd1, 4'd1, EV_REPEAT, 32'd2, SW_BUSY},
        // press while held keeps the count, so the release has no short
        '{ROW_ITEM, OP_KEYS, 12'h002, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd1, 4'd1, EV_PRESS, 32'd3, SW_BUSY},
        '{ROW_ITEM, OP_KEYS, 12'h000, 12'h002, REG_UNUSED, 16'd0,
          1'b1, 6'd1, 4'd1, EV_RELEASE, 32'd3, SW_BUSY},
        // first and last switch keys, press+release in one item, switch releases
        '{ROW_ITEM, OP_KEYS, 12'h880, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd2, 4'd7, EV_PRESS, 32'd4, SW_BUSY},
        '{ROW_ITEM, OP_KEYS, 12'h200, 12'h200, REG_UNUSED, 16'd0,
          1'b0, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_BUSY},
        '{ROW_ITEM, OP_KEYS, 12'h000, 12'h880, REG_UNUSED, 16'd0,
          1'b0, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_BUSY},
        // every key pressed and released: the longest burst
        '{ROW_ITEM, OP_KEYS, 12'hFFF, 12'hFFF, REG_UNUSED, 16'd0,
          1'b1, 6'd36, 4'd0, EV_PRESS, 32'd7, 3'd2},
        // long count zero and period zero: every tick repeats, never short
        '{ROW_CFG, OP_KEYS, 12'h000, 12'h000, REG_LONG_COUNT, 16'd0,
          1'b0, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_BUSY},
        '{ROW_CFG, OP_KEYS, 12'h000, 12'h000, REG_PRESS_PERIOD, 16'd0,
          1'b0, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_BUSY},
        '{ROW_ITEM, OP_KEYS, 12'h020, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd1, 4'd5, EV_PRESS, 32'd19, 3'd4},
        '{ROW_ITEM, OP_TICK, 12'h000, 12'h000, REG_UNUSED, 16'd0,
          1'b1, 6'd1, 4'd5, EV_REPEAT, 32'd19, 3'd4},
        '{ROW_ITEM, OP_KEYS, 12'h000, 12'h020, REG_UNUSED, 16'd0,
          1'b1, 6'd1, 4'd5, EV_RELEASE, 32'd19, 3'd4},
        '{ROW_CFG, OP_KEYS, 12'h000, 12'h000, REG_LONG_COUNT, 16'd255,
          1'b0, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_BUSY},
        '{ROW_CFG, OP_KEYS, 12'h000, 12'h000, REG_PRESS_PERIOD, 16'd65535,
          1'b0, 6'd0, 4'd0, EV_PRESS, 32'd0, SW_BUSY}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [EVT_W-1:0]      m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    key_press_long_repeat_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------------
    // Classifier shadow: its own copy of registers and per-key state
    // ---------------------------------------------------------------------
    logic [PERIOD_W-1:0]  cfg_period  = PRESS_PERIOD_RST;
    logic [COUNT_W-1:0]   cfg_long    = LONG_COUNT_RST;
    logic [TIMEOUT_W-1:0] cfg_timeout = STARTUP_TIMEOUT_RST;

    logic [SEQ_W-1:0]    seq_ctr = '0;
    logic [SEQ_W-1:0]    key_seq   [N_KEYS];
    logic [COUNT_W-1:0]  hold_cnt  [N_KEYS];
    bit                  running   [N_KEYS];
    logic [PERIOD_W-1:0] elapsed   [N_KEYS];
    logic [SW_W-1:0]     sw_pos = SW_UNKNOWN;
    logic [15:0]         boot_elapsed = '0;
    bit                  boot_done = 1'b0;

    key_event_t events_due [$];   // results still owed by the block, oldest first
    int         errors = 0;
    int         burst_left = 0;   // items the sender still pushes back to back
    int         cycle_count = 0;

    function automatic key_event_t key_result(int k, logic [EVT_W-1:0] kind);
        key_event_t r;
        r.key  = KEY_W'(k);
        r.evt  = kind;
        r.seq  = key_seq[k];
        r.sw   = sw_pos;
        r.last = 1'b0;
        return r;
    endfunction

    // Update the shadow for one accepted item and queue the results it owes.
    task automatic classify(input logic op, input logic [11:0] pm, input logic [11:0] rm,
                            output int n, output key_event_t head);
        key_event_t          burst [$];
        logic [PERIOD_W-1:0] period;
        int                  nxt;
        period = (cfg_period == 0) ? PERIOD_W'(1) : cfg_period;
        if (op == OP_KEYS) begin
            // press before release within a key, keys in index order
            for (int k = 0; k < N_KEYS; k++) begin
                if (pm[k]) begin
                    seq_ctr    = seq_ctr + 1;
                    key_seq[k] = seq_ctr;
                    running[k] = 1'b1;
                    elapsed[k] = '0;
                    if (k >= SW_FIRST && k < SW_FIRST + SW_COUNT)
                        sw_pos = SW_W'(k - SW_FIRST);
                    burst.push_back(key_result(k, EV_PRESS));
                end
                if (rm[k]) begin
                    running[k] = 1'b0;
                    elapsed[k] = '0;
                    if (hold_cnt[k] < cfg_long)
                        burst.push_back(key_result(k, EV_SHORT));
                    hold_cnt[k] = '0;
                    burst.push_back(key_result(k, EV_RELEASE));
                end
            end
        end
        else begin
            // startup timeout runs ahead of the hold timers, once
            if (!boot_done) begin
                if (boot_elapsed != 16'hFFFF)
                    boot_elapsed++;
                if (boot_elapsed >= cfg_timeout) begin
                    boot_done = 1'b1;
                    if (sw_pos == SW_UNKNOWN)
                        sw_pos = SW_BUSY;
                end
            end
            for (int k = 0; k < N_KEYS; k++) begin
                if (running[k]) begin
                    elapsed[k]++;
                    if (elapsed[k] >= period) begin
                        elapsed[k] = '0;
                        nxt = int'(hold_cnt[k]) + 1;
                        if (nxt == int'(cfg_long)) begin
                            hold_cnt[k] = COUNT_W'(nxt);
                            burst.push_back(key_result(k, EV_LONG));
                        end
                        else if (nxt > int'(cfg_long))
                            burst.push_back(key_result(k, EV_REPEAT));
                        else
                            hold_cnt[k] = COUNT_W'(nxt);
                    end
                end
            end
        end
        n = burst.size();
        head = '0;
        if (n > 0) begin
            burst[n-1].last = 1'b1;
            head = burst[0];
        end
        foreach (burst[i])
            events_due.push_back(burst[i]);
    endtask

    task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                               input logic [SEQ_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Sender: one transaction per item, in bursts with random gaps
    // ---------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [11:0] pm, input logic [11:0] rm,
                             output int n, output key_event_t head);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {rm, pm};
        do
            @(posedge clk);
        while (!s_axis_tready);
        classify(op, pm, rm, n, head);
        // valid stays up while the burst lasts; the next call replaces the data
        if (burst_left > 0)
            burst_left--;
        else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Register write; valid stays high when another write follows at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val,
                             input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PRESS_PERIOD:    cfg_period  = val;
            REG_LONG_COUNT:      cfg_long    = val[COUNT_W-1:0];
            REG_STARTUP_TIMEOUT: cfg_timeout = val;
            default: ;  // unused index: no register changes
        endcase
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    // Drain: every owed result out, then a few cycles for an item with no results.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Receiver: ready toggles with random stall and run lengths,
    // now and then a long stretch with no stall at all
    // ---------------------------------------------------------------------
    int ready_hold = 0;

    always @(posedge clk) begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else begin
            m_axis_tready <= ~m_axis_tready;
            if (m_axis_tready)
                ready_hold <= $urandom_range(0, 6);
            else if ($urandom_range(0, 3) == 0)
                ready_hold <= $urandom_range(20, 60);
            else
                ready_hold <= $urandom_range(0, 5);
        end
    end

    // Output check: each result transaction against the oldest owed result.
    always @(posedge clk) begin : check_out
        key_event_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (events_due.size() == 0) begin
                $error("unexpected result: key %0d type %0d seq %0d",
                       m_axis_tdata[3:0], m_axis_tuser, m_axis_tdata[35:4]);
                errors++;
            end
            else begin
                due = events_due.pop_front();
                check_field("key", due.key, m_axis_tdata[3:0]);
                check_field("event_type", due.evt, m_axis_tuser);
                check_field("sequence_res", due.seq, m_axis_tdata[35:4]);
                check_field("sw_position", due.sw, m_axis_tdata[38:36]);
                check_field("tdata pad", 0, m_axis_tdata[39]);
                check_field("last", due.last, m_axis_tlast);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("[key_press_long_repeat_classifier] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus: directed table, then random phases over several settings
    // ---------------------------------------------------------------------
    initial begin
        int          n;
        key_event_t  head;
        logic [11:0] held;
        logic [11:0] pm;
        logic [11:0] rm;
        logic        op;
        int          pick;
        string       tag;

        for (int k = 0; k < N_KEYS; k++) begin
            key_seq[k]  = '0;
            hold_cnt[k] = '0;
            running[k]  = 1'b0;
            elapsed[k]  = '0;
        end
        held = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i]) begin
            if (PLAN[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(PLAN[i].reg_idx, PLAN[i].reg_val, 1'b0);
            end
            else begin
                send_item(PLAN[i].op, PLAN[i].pm, PLAN[i].rm, n, head);
                // typed-in rows cross-check the shadow itself
                if (PLAN[i].has_exp) begin
                    tag = $sformatf("row %0d", i);
                    check_field({tag, " result count"}, PLAN[i].exp_cnt, n);
                    if (n > 0 && n == PLAN[i].exp_cnt) begin
                        check_field({tag, " key"}, PLAN[i].exp_key, head.key);
                        check_field({tag, " event_type"}, PLAN[i].exp_evt, head.evt);
                        check_field({tag, " sequence_res"}, PLAN[i].exp_seq, head.seq);
                        check_field({tag, " sw_position"}, PLAN[i].exp_sw, head.sw);
                    end
                end
            end
        end

        // Random part. Held keys carry across phases, so a lowered long count
        // meets keys already past it.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            write_reg(REG_PRESS_PERIOD, PHASE_PERIOD[ph], 1'b1);
            write_reg(REG_LONG_COUNT, 16'(PHASE_LONG[ph]), 1'b1);
            write_reg(REG_STARTUP_TIMEOUT, PHASE_TIMEOUT[ph], 1'b0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    // tick, random junk in tdata
                    op = OP_TICK;
                    pm = 12'($urandom);
                    rm = 12'($urandom);
                end
                else if (pick < 85) begin
                    // plausible keyboard: sparse presses of free keys, releases of held ones
                    op = OP_KEYS;
                    pm = 12'($urandom & $urandom) & ~held;
                    rm = held & 12'($urandom & $urandom);
                end
                else begin
                    // noise: double presses, releases of idle keys
                    op = OP_KEYS;
                    pm = 12'($urandom);
                    rm = 12'($urandom);
                end
                if (op == OP_KEYS)
                    held = (held | pm) & ~rm;
                send_item(op, pm, rm, n, head);
            end
        end

        wait_idle();
        if (errors == 0)
            $display("[key_press_long_repeat_classifier] OK");
        else
            $display("[key_press_long_repeat_classifier] ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/kplr_pkg.sv
rtl/kplr_lane.sv
rtl/kplr_merge.sv
rtl/key_press_long_repeat_classifier.sv
verif/key_press_long_repeat_classifier_tb.sv
